// ===== rtl/core/pr_pkg.sv =====
// shared types, codes and field widths of the pagerank block
package pr_pkg;

   localparam int NODE_W        = 11;
   localparam int RANK_Q_W      = 31;
   localparam int ITER_W        = 16;
   localparam int EDGES_W       = 14;
   localparam int CSR_DATA_W    = 31;
   localparam int CSR_INDEX_W   = 2;

   localparam int DEF_MAX_NODES = 1024;
   localparam int DEF_MAX_EDGES = 8192;
   localparam int DEF_RANK_BITS = 32;

   localparam logic [NODE_W-1:0]   NODE_COUNT_RST = 11'd1024;
   localparam logic [RANK_Q_W-1:0] TOLERANCE_RST  = 31'd107374;
   localparam logic [ITER_W-1:0]   ITER_LIMIT_RST = 16'd1000;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_RUN   = 2'd1,
      ACT_READ  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_LIMIT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_NODE_COUNT = 2'd0,
      CSR_INDEX_BASE = 2'd1,
      CSR_TOLERANCE  = 2'd2,
      CSR_ITER_LIMIT = 2'd3
   } csr_type;

   // one-based numbering wraps node zero to the top of the field
   function automatic logic [NODE_W-1:0] map_node(input logic [NODE_W-1:0] raw,
                                                  input logic            base);
      return base ? raw - NODE_W'(1) : raw;
   endfunction

endpackage

// ===== rtl/core/pr_ram.sv =====
// generic simple dual-port ram with registered read
module pr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/pr_div.sv =====
// restoring divider, one quotient bit per cycle
module pr_div #(
   parameter int NUM_W = 39,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             act_ff, act_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_sub;
   logic             ge;

   assign trial     = {rem_ff, quo_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign ge        = (trial >= {1'b0, den_ff});

   always_comb begin
      act_in  = act_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         act_in = 1'b1;
         cnt_in = CW'(NUM_W);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (act_ff) begin
         rem_in = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            act_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         act_ff  <= act_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/core/pagerank_power_iteration.sv =====
// pagerank engine: edge list load, power iteration run and rank read
//
// Edges, out-degrees and both rank vectors sit in registered-read rams.
// Rejected loads and reads answer in the cycle after start; accepted ones
// pass through S_LOAD2 or S_READ2 before their registered answer. A clear,
// and reset, sweep the out-degree ram one entry per cycle (busy stays high
// meanwhile; csr writes are still taken). A run sets up with two divides and
// an init sweep over n nodes, then per iteration fills n teleport entries,
// reads and checks every stored edge and, for an edge that is used, waits
// on the serial divider and adds, then sweeps the difference. The divider,
// one quotient bit per cycle, sets the run time. The result strobe rsp_valid
// is high for exactly one cycle per transaction and cannot be held off.
module pagerank_power_iteration import pr_pkg::*; #(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int MAX_EDGES = DEF_MAX_EDGES,
   parameter int RANK_BITS = DEF_RANK_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_action,
   input  logic [NODE_W-1:0]      req_from_node,
   input  logic [NODE_W-1:0]      req_to_node,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [RANK_Q_W-1:0]    rsp_rank_value,
   output logic [ITER_W-1:0]      rsp_iterations_done,
   output logic [EDGES_W-1:0]     rsp_edges_stored,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NB     = $clog2(MAX_NODES);
   localparam int EA     = $clog2(MAX_EDGES);
   localparam int EB     = $clog2(MAX_EDGES + 1);
   localparam int FB     = RANK_BITS - 2;
   localparam int UP     = (FB >= 30) ? FB - 30 : 0;
   localparam int DN     = (FB >= 30) ? 0 : 30 - FB;
   localparam int NUM_W  = RANK_BITS + 7;
   localparam int DEN_W  = ((EB > NODE_W) ? EB : NODE_W) + 7;
   localparam int DIFF_W = RANK_BITS + NODE_W;
   localparam int CMP_W  = RANK_BITS + NODE_W + 32;
   localparam int QW     = RANK_BITS + 32;
   localparam int XW     = NODE_W + NB;
   localparam int SW     = RANK_BITS + 1;

   localparam logic [RANK_BITS-1:0] RANK_MAX = {1'b0, {(RANK_BITS-1){1'b1}}};
   localparam logic [NUM_W-1:0]     ONE_NUM  = NUM_W'(1) << FB;
   localparam logic [NUM_W-1:0]     TELE_NUM = NUM_W'(15) << FB;

   typedef enum logic [14:0] {
      S_IDLE       = 15'b000000000000001,
      S_CLR        = 15'b000000000000010,
      S_LOAD2      = 15'b000000000000100,
      S_READ2      = 15'b000000000001000,
      S_DIV_INIT   = 15'b000000000010000,
      S_DIV_TELE   = 15'b000000000100000,
      S_INIT_SWEEP = 15'b000000001000000,
      S_TELE_SWEEP = 15'b000000010000000,
      S_EDGE_RD    = 15'b000000100000000,
      S_EDGE_CHK   = 15'b000001000000000,
      S_EDGE_DEG   = 15'b000010000000000,
      S_EDGE_DIV   = 15'b000100000000000,
      S_EDGE_ADD   = 15'b001000000000000,
      S_DIFF       = 15'b010000000000000,
      S_CHECK      = 15'b100000000000000
   } state_type;

   function automatic logic [NB-1:0] to_addr(input logic [NODE_W-1:0] x);
      logic [XW-1:0] t;
      t = XW'(x);
      return t[NB-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic [NODE_W-1:0]      node_count_ff, node_count_in;
   logic                   index_base_ff, index_base_in;
   logic [RANK_Q_W-1:0]    tol_ff, tol_in;
   logic [ITER_W-1:0]      limit_ff, limit_in;
   logic [EB-1:0]          edge_total_ff, edge_total_in;
   logic [ITER_W-1:0]      iter_count_ff, iter_count_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;
   logic [NODE_W-1:0]      i_ff, i_in;
   logic                   pv_ff, pv_in;
   logic [EB-1:0]          e_ff, e_in;
   logic [NB-1:0]          clr_ff, clr_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NB-1:0]          pidx_ff, pidx_in;
   logic [NB-1:0]          u_ff, u_in;
   logic [NB-1:0]          v_ff, v_in;
   logic [RANK_BITS-1:0]   init_ff, init_in;
   logic [RANK_BITS-1:0]   tele_ff, tele_in;
   logic [DIFF_W-1:0]      diff_ff, diff_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [RANK_Q_W-1:0]    rsp_rank_ff, rsp_rank_in;

   logic                   edge_we;
   logic [EA-1:0]          edge_waddr, edge_raddr;
   logic [2*NB-1:0]        edge_wdata, edge_rdata;
   logic                   deg_we;
   logic [NB-1:0]          deg_waddr, deg_raddr;
   logic [EB-1:0]          deg_wdata, deg_rdata;
   logic                   cur_we;
   logic [NB-1:0]          cur_waddr, cur_raddr;
   logic [RANK_BITS-1:0]   cur_wdata, cur_rdata;
   logic                   next_we;
   logic [NB-1:0]          next_waddr, next_raddr;
   logic [RANK_BITS-1:0]   next_wdata, next_rdata;

   logic                   div_start, div_done;
   logic [NUM_W-1:0]       div_num, div_q;
   logic [DEN_W-1:0]       div_den;

   logic [NODE_W-1:0]      n;
   logic [ITER_W-1:0]      lim;
   logic [NODE_W-1:0]      mu, mv;
   logic                   u_ok, v_ok;
   logic [NB-1:0]          eu, ev;
   logic                   e_ok;
   logic [CMP_W-1:0]       tol_cmp;
   logic [QW-1:0]          rank_q;
   logic [RANK_BITS-1:0]   absdiff;
   logic [SW-1:0]          sum;
   logic [RANK_BITS-1:0]   sat;
   logic                   accept;

   always_comb begin
      if (node_count_ff == '0) begin
         n = NODE_W'(1);
      end else if (32'(node_count_ff) > 32'(MAX_NODES)) begin
         n = NODE_W'(MAX_NODES);
      end else begin
         n = node_count_ff;
      end
   end

   assign lim     = (limit_ff == '0) ? ITER_W'(1) : limit_ff;
   assign mu      = map_node(req_from_node, index_base_ff);
   assign mv      = map_node(req_to_node, index_base_ff);
   assign u_ok    = (mu < n);
   assign v_ok    = (mv < n);
   assign eu      = edge_rdata[2*NB-1:NB];
   assign ev      = edge_rdata[NB-1:0];
   assign e_ok    = (XW'(eu) < XW'(n)) && (XW'(ev) < XW'(n));
   assign tol_cmp = (CMP_W'(tol_ff) << UP) >> DN;
   assign rank_q  = (QW'(cur_rdata) >> UP) << DN;
   assign absdiff = (next_rdata >= cur_rdata) ? next_rdata - cur_rdata
                                               : cur_rdata - next_rdata;
   assign sum     = {1'b0, next_rdata} + {1'b0, div_q[RANK_BITS-1:0]};
   assign sat     = (sum > SW'(RANK_MAX)) ? RANK_MAX : sum[RANK_BITS-1:0];
   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;

   // csr writes
   always_comb begin
      node_count_in = node_count_ff;
      index_base_in = index_base_ff;
      tol_in        = tol_ff;
      limit_in      = limit_ff;
      if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_NODE_COUNT: node_count_in = csr_wdata[NODE_W-1:0];
            CSR_INDEX_BASE: index_base_in = csr_wdata[0];
            CSR_TOLERANCE:  tol_in        = csr_wdata[RANK_Q_W-1:0];
            CSR_ITER_LIMIT: limit_in      = csr_wdata[ITER_W-1:0];
         endcase
      end
   end

   // divider operands
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      unique case (state_ff)
         S_IDLE: begin
            div_start = accept && (action_type'(req_action) == ACT_RUN);
            div_num   = ONE_NUM;
            div_den   = DEN_W'(n);
         end
         S_DIV_INIT: begin
            div_start = div_done;
            div_num   = TELE_NUM;
            div_den   = DEN_W'(n) * DEN_W'(100);
         end
         S_EDGE_DEG: begin
            div_start = (deg_rdata != '0);
            div_num   = NUM_W'(cur_rdata) * NUM_W'(85);
            div_den   = DEN_W'(deg_rdata) * DEN_W'(100);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      edge_total_in = edge_total_ff;
      iter_count_in = iter_count_ff;
      iter_in       = iter_ff;
      i_in          = i_ff;
      pv_in         = pv_ff;
      e_in          = e_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      rsp_valid_in  = 1'b0;
      pidx_in       = pidx_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      init_in       = init_ff;
      tele_in       = tele_ff;
      diff_in       = diff_ff;
      rsp_status_in = ST_OK;
      rsp_rank_in   = '0;

      edge_we    = 1'b0;
      edge_waddr = '0;
      edge_wdata = '0;
      edge_raddr = '0;
      deg_we     = 1'b0;
      deg_waddr  = '0;
      deg_wdata  = '0;
      deg_raddr  = '0;
      cur_we     = 1'b0;
      cur_waddr  = '0;
      cur_wdata  = '0;
      cur_raddr  = '0;
      next_we    = 1'b0;
      next_waddr = '0;
      next_wdata = '0;
      next_raddr = '0;

      unique case (state_ff)
         S_CLR: begin
            deg_we    = 1'b1;
            deg_waddr = clr_ff;
            clr_in    = clr_ff + NB'(1);
            if (clr_ff == NB'(MAX_NODES - 1)) begin
               state_in     = S_IDLE;
               rsp_valid_in = clr_rsp_ff;
            end
         end
         S_IDLE: begin
            if (start) begin
               unique case (action_type'(req_action))
                  ACT_LOAD: begin
                     if (!u_ok || !v_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else if (edge_total_ff == EB'(MAX_EDGES)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        edge_we    = 1'b1;
                        edge_waddr = edge_total_ff[EA-1:0];
                        edge_wdata = {to_addr(mu), to_addr(mv)};
                        deg_raddr  = to_addr(mu);
                        u_in       = to_addr(mu);
                        state_in   = S_LOAD2;
                     end
                  end
                  ACT_RUN: begin
                     state_in = S_DIV_INIT;
                  end
                  ACT_READ: begin
                     if (!v_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        cur_raddr = to_addr(mv);
                        state_in  = S_READ2;
                     end
                  end
                  ACT_CLEAR: begin
                     edge_total_in = '0;
                     clr_in        = '0;
                     clr_rsp_in    = 1'b1;
                     state_in      = S_CLR;
                  end
               endcase
            end
         end
         S_LOAD2: begin
            deg_we        = 1'b1;
            deg_waddr     = u_ff;
            deg_wdata     = deg_rdata + EB'(1);
            edge_total_in = edge_total_ff + EB'(1);
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end
         S_READ2: begin
            rsp_valid_in = 1'b1;
            rsp_rank_in  = rank_q[RANK_Q_W-1:0];
            state_in     = S_IDLE;
         end
         S_DIV_INIT: begin
            if (div_done) begin
               init_in  = div_q[RANK_BITS-1:0];
               state_in = S_DIV_TELE;
            end
         end
         S_DIV_TELE: begin
            if (div_done) begin
               tele_in  = div_q[RANK_BITS-1:0];
               i_in     = '0;
               state_in = S_INIT_SWEEP;
            end
         end
         S_INIT_SWEEP: begin
            cur_we    = 1'b1;
            cur_waddr = to_addr(i_ff);
            cur_wdata = init_ff;
            if (i_ff == n - NODE_W'(1)) begin
               i_in     = '0;
               iter_in  = ITER_W'(1);
               state_in = S_TELE_SWEEP;
            end else begin
               i_in = i_ff + NODE_W'(1);
            end
         end
         S_TELE_SWEEP: begin
            next_we    = 1'b1;
            next_waddr = to_addr(i_ff);
            next_wdata = tele_ff;
            if (i_ff == n - NODE_W'(1)) begin
               e_in     = '0;
               state_in = S_EDGE_RD;
            end else begin
               i_in = i_ff + NODE_W'(1);
            end
         end
         S_EDGE_RD: begin
            if (e_ff == edge_total_ff) begin
               i_in     = '0;
               pv_in    = 1'b0;
               diff_in  = '0;
               state_in = S_DIFF;
            end else begin
               edge_raddr = e_ff[EA-1:0];
               state_in   = S_EDGE_CHK;
            end
         end
         S_EDGE_CHK: begin
            if (e_ok) begin
               deg_raddr = eu;
               cur_raddr = eu;
               v_in      = ev;
               state_in  = S_EDGE_DEG;
            end else begin
               e_in     = e_ff + EB'(1);
               state_in = S_EDGE_RD;
            end
         end
         S_EDGE_DEG: begin
            if (deg_rdata == '0) begin
               e_in     = e_ff + EB'(1);
               state_in = S_EDGE_RD;
            end else begin
               state_in = S_EDGE_DIV;
            end
         end
         S_EDGE_DIV: begin
            if (div_done) begin
               next_raddr = v_ff;
               state_in   = S_EDGE_ADD;
            end
         end
         S_EDGE_ADD: begin
            next_we    = 1'b1;
            next_waddr = v_ff;
            next_wdata = sat;
            e_in       = e_ff + EB'(1);
            state_in   = S_EDGE_RD;
         end
         S_DIFF: begin
            if (pv_ff) begin
               cur_we    = 1'b1;
               cur_waddr = pidx_ff;
               cur_wdata = next_rdata;
               diff_in   = diff_ff + DIFF_W'(absdiff);
            end
            if (i_ff != n) begin
               cur_raddr  = to_addr(i_ff);
               next_raddr = to_addr(i_ff);
               pidx_in    = to_addr(i_ff);
               pv_in      = 1'b1;
               i_in       = i_ff + NODE_W'(1);
            end else begin
               pv_in = 1'b0;
               if (!pv_ff) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (CMP_W'(diff_ff) <= tol_cmp) begin
               iter_count_in = iter_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (iter_ff >= lim) begin
               iter_count_in = iter_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_LIMIT;
               state_in      = S_IDLE;
            end else begin
               iter_in  = iter_ff + ITER_W'(1);
               i_in     = '0;
               state_in = S_TELE_SWEEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         node_count_ff <= NODE_COUNT_RST;
         index_base_ff <= 1'b0;
         tol_ff        <= TOLERANCE_RST;
         limit_ff      <= ITER_LIMIT_RST;
         edge_total_ff <= '0;
         iter_count_ff <= '0;
         iter_ff       <= '0;
         i_ff          <= '0;
         pv_ff         <= 1'b0;
         e_ff          <= '0;
         clr_ff        <= '0;
         clr_rsp_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         index_base_ff <= index_base_in;
         tol_ff        <= tol_in;
         limit_ff      <= limit_in;
         edge_total_ff <= edge_total_in;
         iter_count_ff <= iter_count_in;
         iter_ff       <= iter_in;
         i_ff          <= i_in;
         pv_ff         <= pv_in;
         e_ff          <= e_in;
         clr_ff        <= clr_in;
         clr_rsp_ff    <= clr_rsp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff       <= pidx_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      init_ff       <= init_in;
      tele_ff       <= tele_in;
      diff_ff       <= diff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rank_ff   <= rsp_rank_in;
   end

   pr_ram #(.WIDTH(2 * NB), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   pr_ram #(.WIDTH(EB), .DEPTH(MAX_NODES)) u_deg_ram (
      .clock (clock),
      .we    (deg_we),
      .waddr (deg_waddr),
      .wdata (deg_wdata),
      .raddr (deg_raddr),
      .rdata (deg_rdata)
   );

   pr_ram #(.WIDTH(RANK_BITS), .DEPTH(MAX_NODES)) u_cur_ram (
      .clock (clock),
      .we    (cur_we),
      .waddr (cur_waddr),
      .wdata (cur_wdata),
      .raddr (cur_raddr),
      .rdata (cur_rdata)
   );

   pr_ram #(.WIDTH(RANK_BITS), .DEPTH(MAX_NODES)) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .waddr (next_waddr),
      .wdata (next_wdata),
      .raddr (next_raddr),
      .rdata (next_rdata)
   );

   pr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_rank_value      = rsp_rank_ff;
   assign rsp_iterations_done = iter_count_ff;
   assign rsp_edges_stored    = EDGES_W'(edge_total_ff);

   a_edge_total_bound: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= EB'(MAX_EDGES))
      else $error("edge count beyond store size");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_INIT || state_ff == S_DIV_TELE ||
                    state_ff == S_EDGE_DIV))
      else $error("divider finished outside a divide wait");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT_SWEEP || state_ff == S_TELE_SWEEP) |-> (i_ff < n))
      else $error("rank sweep past node count");

   a_run_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && action_type'(req_action) == ACT_RUN) |=> (busy && !rsp_valid))
      else $error("run transaction did not start");

   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_LIMIT) |-> (rsp_iterations_done == lim))
      else $error("limit status with wrong iteration count");

endmodule

// ===== test/testbench.sv =====
// testbench for the pagerank power iteration block: directed and random transactions
module testbench;
   import pr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned CYCLE_LIMIT = 64'd4000000;
   localparam int EDGE_CAP = 8192;
   localparam int NODE_CAP = 1024;

   typedef struct packed {
      status_type           status;
      logic [RANK_Q_W-1:0]  rank_value;
      logic [ITER_W-1:0]    iterations;
      logic [EDGES_W-1:0]   edges;
   } rank_reply;

   class rank_scoreboard;
      rank_reply        expected_q[$];
      int unsigned      errors;
      logic [10:0]      node_count;
      logic             index_base;
      logic [30:0]      tolerance;
      logic [15:0]      iter_limit;
      int unsigned      edge_src[EDGE_CAP];
      int unsigned      edge_dst[EDGE_CAP];
      int unsigned      edge_total;
      int unsigned      fanout[NODE_CAP];
      longint unsigned  rank_now[NODE_CAP];
      bit               rank_known[NODE_CAP];
      logic [15:0]      iter_count;

      function new();
         errors = 0;
         node_count = NODE_COUNT_RST;
         index_base = 1'b0;
         tolerance = TOLERANCE_RST;
         iter_limit = ITER_LIMIT_RST;
         edge_total = 0;
         iter_count = 0;
         foreach (fanout[i]) fanout[i] = 0;
         foreach (rank_known[i]) rank_known[i] = 1'b0;
      endfunction

      function void write_reg(csr_type idx, logic [30:0] value);
         case (idx)
            CSR_NODE_COUNT: node_count = value[10:0];
            CSR_INDEX_BASE: index_base = value[0];
            CSR_TOLERANCE:  tolerance = value;
            CSR_ITER_LIMIT: iter_limit = value[15:0];
         endcase
      endfunction

      function int unsigned nodes();
         if (node_count < 1) return 1;
         if (node_count > NODE_CAP) return NODE_CAP;
         return node_count;
      endfunction

      function int unsigned to_index(logic [10:0] raw);
         logic [10:0] v;
         v = index_base ? raw - 11'd1 : raw;
         return v;
      endfunction

      function status_type iterate();
         int unsigned n, lim, iter;
         longint unsigned one, tele, diff, deg;
         longint unsigned fresh[NODE_CAP];
         n = nodes();
         lim = (iter_limit == 0) ? 1 : iter_limit;
         one = 64'd1 << 30;
         tele = one * 15 / (100 * n);
         iter = 0;
         for (int i = 0; i < n; i++) begin
            rank_now[i] = one / n;
            rank_known[i] = 1'b1;
         end
         forever begin
            diff = 0;
            iter++;
            for (int i = 0; i < n; i++) fresh[i] = tele;
            for (int e = 0; e < edge_total; e++) begin
               if (edge_src[e] < n && edge_dst[e] < n && fanout[edge_src[e]] != 0) begin
                  deg = fanout[edge_src[e]];
                  fresh[edge_dst[e]] += rank_now[edge_src[e]] * 85 / (100 * deg);
                  if (fresh[edge_dst[e]] > 64'h7FFF_FFFF) fresh[edge_dst[e]] = 64'h7FFF_FFFF;
               end
            end
            for (int i = 0; i < n; i++) begin
               diff += (fresh[i] >= rank_now[i]) ? fresh[i] - rank_now[i]
                                                 : rank_now[i] - fresh[i];
               rank_now[i] = fresh[i];
            end
            if (diff <= tolerance) begin
               iter_count = iter;
               return ST_OK;
            end
            if (iter >= lim) begin
               iter_count = iter;
               return ST_LIMIT;
            end
         end
      endfunction

      function void note_request(action_type act, logic [10:0] from_raw, logic [10:0] to_raw);
         rank_reply r;
         int unsigned n, u, v;
         n = nodes();
         r.status = ST_OK;
         r.rank_value = '0;
         u = to_index(from_raw);
         v = to_index(to_raw);
         case (act)
            ACT_LOAD: begin
               if (u >= n || v >= n) r.status = ST_RANGE;
               else if (edge_total >= EDGE_CAP) r.status = ST_FULL;
               else begin
                  edge_src[edge_total] = u;
                  edge_dst[edge_total] = v;
                  edge_total++;
                  fanout[u]++;
               end
            end
            ACT_RUN: r.status = iterate();
            ACT_READ: begin
               if (v >= n) r.status = ST_RANGE;
               else r.rank_value = rank_now[v][30:0];
            end
            ACT_CLEAR: begin
               edge_total = 0;
               foreach (fanout[i]) fanout[i] = 0;
            end
         endcase
         r.iterations = iter_count;
         r.edges = edge_total[13:0];
         expected_q.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [1:0] status, logic [30:0] rank_value,
                        logic [15:0] iterations, logic [13:0] edges);
         rank_reply r;
         if (expected_q.size() == 0) begin
            report("result with no transaction pending");
         end else begin
            r = expected_q.pop_front();
            if (status !== r.status)
               report($sformatf("status %0d, want %0d", status, r.status));
            if (rank_value !== r.rank_value)
               report($sformatf("rank_value %0h, want %0h", rank_value, r.rank_value));
            if (iterations !== r.iterations)
               report($sformatf("iterations_done %0d, want %0d", iterations, r.iterations));
            if (edges !== r.edges)
               report($sformatf("edges_stored %0d, want %0d", edges, r.edges));
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_action = '0;
   logic [NODE_W-1:0]      req_from_node = '0;
   logic [NODE_W-1:0]      req_to_node = '0;
   logic                   rsp_valid;
   logic [1:0]             rsp_status;
   logic [RANK_Q_W-1:0]    rsp_rank_value;
   logic [ITER_W-1:0]      rsp_iterations_done;
   logic [EDGES_W-1:0]     rsp_edges_stored;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rank_scoreboard  sb = new();
   longint unsigned cycles = 0;

   pagerank_power_iteration DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_rank_value, rsp_iterations_done, rsp_edges_stored);
   end

   task automatic send(action_type act, logic [10:0] from_raw, logic [10:0] to_raw, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_from_node <= from_raw;
      req_to_node <= to_raw;
      do @(posedge clock); while (busy);
      sb.note_request(act, from_raw, to_raw);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, logic [30:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   function automatic logic [10:0] raw_of(int unsigned v);
      return sb.index_base ? 11'(v + 1) : 11'(v);
   endfunction

   task automatic read_any(int gap);
      int unsigned n, v, tries;
      n = sb.nodes();
      v = $urandom_range(0, n - 1);
      tries = 0;
      while (!sb.rank_known[v] && tries < 8) begin
         v = $urandom_range(0, n - 1);
         tries++;
      end
      if (sb.rank_known[v]) send(ACT_READ, 11'($urandom), raw_of(v), gap);
      else send(ACT_READ, 11'($urandom), raw_of(n + $urandom_range(0, 20)), gap);
   endtask

   task automatic random_phase();
      int unsigned kind, n, pick, gap;
      logic [30:0] tol;
      drain();
      kind = $urandom_range(0, 9);
      if (kind == 0) write_csr(CSR_NODE_COUNT, 31'($urandom_range(1024, 2047)));
      else if (kind == 1) write_csr(CSR_NODE_COUNT, 31'($urandom_range(0, 1)));
      else write_csr(CSR_NODE_COUNT, 31'($urandom_range(2, 12)));
      write_csr(CSR_INDEX_BASE, 31'($urandom_range(0, 1)));
      pick = $urandom_range(0, 5);
      tol = (pick == 0) ? 31'd0 : (pick == 1) ? 31'd1073741824 :
            (pick == 2) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
      write_csr(CSR_TOLERANCE, tol);
      write_csr(CSR_ITER_LIMIT, 31'((kind == 0) ? $urandom_range(0, 2) : $urandom_range(0, 4)));
      n = sb.nodes();
      send(ACT_CLEAR, 11'($urandom), 11'($urandom), 0);
      for (int k = 0; k < 60; k++) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
         pick = $urandom_range(0, 99);
         if (pick < 4 && sb.edge_total <= 32) begin
            send(ACT_RUN, 11'($urandom), 11'($urandom), gap);
         end else if (pick < 30) begin
            read_any(gap);
         end else if (pick < 32) begin
            send(ACT_CLEAR, 11'($urandom), 11'($urandom), gap);
         end else if (pick < 45 || sb.edge_total > 28) begin
            send(ACT_LOAD, 11'($urandom), 11'($urandom), gap);
         end else begin
            send(ACT_LOAD, raw_of($urandom_range(0, n - 1)), raw_of($urandom_range(0, n - 1)),
                 gap);
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // node past the default size reads as out of range
      send(ACT_READ, 11'd0, 11'd2047, 0);
      drain();
      write_csr(CSR_NODE_COUNT, 31'd4);
      write_csr(CSR_INDEX_BASE, 31'd0);
      write_csr(CSR_TOLERANCE, 31'd0);
      write_csr(CSR_ITER_LIMIT, 31'd3);
      send(ACT_LOAD, 11'd0, 11'd1, 0);
      send(ACT_LOAD, 11'd1, 11'd2, 2);
      send(ACT_LOAD, 11'd2, 11'd0, 0);
      send(ACT_LOAD, 11'd3, 11'd3, 1);
      send(ACT_LOAD, 11'd5, 11'd0, 0);
      send(ACT_LOAD, 11'd0, 11'd2047, 0);
      send(ACT_RUN, 11'd0, 11'd0, 0);
      for (int i = 0; i < 5; i++) send(ACT_READ, 11'd0, 11'(i), i % 2);
      drain();
      write_csr(CSR_INDEX_BASE, 31'd1);
      send(ACT_LOAD, 11'd0, 11'd1, 0);
      send(ACT_LOAD, 11'd1, 11'd4, 0);
      send(ACT_READ, 11'd0, 11'd4, 0);
      send(ACT_READ, 11'd0, 11'd0, 0);
      drain();
      // shrink the graph below loaded edges
      write_csr(CSR_NODE_COUNT, 31'd2);
      write_csr(CSR_INDEX_BASE, 31'd0);
      write_csr(CSR_ITER_LIMIT, 31'd0);
      send(ACT_RUN, 11'd0, 11'd0, 0);
      send(ACT_READ, 11'd0, 11'd1, 0);
      send(ACT_CLEAR, 11'd0, 11'd0, 0);
      drain();
      write_csr(CSR_NODE_COUNT, 31'd1024);
      write_csr(CSR_ITER_LIMIT, 31'd65535);
      send(ACT_RUN, 11'd0, 11'd0, 0);
      send(ACT_READ, 11'd0, 11'd1023, 0);
      drain();
      write_csr(CSR_TOLERANCE, 31'd1073741824);
      write_csr(CSR_NODE_COUNT, 31'd0);
      send(ACT_RUN, 11'd0, 11'd0, 0);
      send(ACT_READ, 11'd0, 11'd0, 0);
      send(ACT_CLEAR, 11'd0, 11'd0, 0);
      drain();

      for (int p = 0; p < 30; p++) random_phase();

      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule
